[hdl/tlu_pkg.sv]
// ----------------------------------------------------------------------------
// tlu_pkg: shared types and constants for the tridiagonal LU factor block
// Holds status codes, default parameters and the divider handshake type.
// ----------------------------------------------------------------------------
package tlu_pkg;

  localparam int MAX_COLS_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 24;

  localparam int DATA_W   = 32;
  localparam int WIDE_W   = 2 * DATA_W;
  localparam int COL_W    = 10;
  localparam int STATUS_W = 2;

  // Quotient bits resolved by the divider, one per step.
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SKIP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd3;

  typedef struct packed {
    logic done;  // quotient ready, one cycle
    logic ovf;   // quotient does not fit in DATA_W bits
  } div_stat_t;

endpackage

[hdl/tlu_div.sv]
// ----------------------------------------------------------------------------
// tlu_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, with an up-front overflow
// check so only the low DATA_W quotient bits need to be resolved.
// ----------------------------------------------------------------------------
module tlu_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tlu_pkg::WIDE_W-1:0]       num,
  input  logic [tlu_pkg::DATA_W-1:0]       den,
  output tlu_pkg::div_stat_t               stat,
  output logic [tlu_pkg::DATA_W-1:0]       quot
);

  logic                             busy;
  logic                             done;
  logic                             ovf;
  logic [tlu_pkg::DIV_CNT_W-1:0]    count;
  logic [tlu_pkg::DATA_W-1:0]       rem;
  logic [tlu_pkg::DATA_W-1:0]       lo;
  logic [tlu_pkg::DATA_W-1:0]       den_reg;
  logic [tlu_pkg::DATA_W:0]         trial;
  logic                             num_ovf;

  // Quotient overflows DATA_W bits exactly when the high half reaches den.
  assign num_ovf = (num[tlu_pkg::WIDE_W-1:tlu_pkg::DATA_W] >= den);
  assign trial   = {rem, lo[tlu_pkg::DATA_W-1]} - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !num_ovf;
        done <= num_ovf;
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf     <= num_ovf;
      rem     <= num[tlu_pkg::WIDE_W-1:tlu_pkg::DATA_W];
      lo      <= num[tlu_pkg::DATA_W-1:0];
      den_reg <= den;
      count   <= tlu_pkg::DIV_CNT_W'(tlu_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      // Shift the next dividend bit in; keep the difference when it fits.
      if (!trial[tlu_pkg::DATA_W]) begin
        rem <= trial[tlu_pkg::DATA_W-1:0];
        lo  <= {lo[tlu_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[tlu_pkg::DATA_W-2:0], lo[tlu_pkg::DATA_W-1]};
        lo  <= {lo[tlu_pkg::DATA_W-2:0], 1'b0};
      end
      count <= count - 1'b1;
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;
  assign quot      = lo;

endmodule

[hdl/tridiagonal_lu_factor_top.sv]
// ----------------------------------------------------------------------------
// tridiagonal_lu_factor_top: column-serial tridiagonal LU factorization
// Each input item is one matrix column (super, diag, sub, last flag); each
// result item carries pivot u, multiplier l, status and the column number.
//
// Usage:
//   Input channel in_valid/in_stall; an item is taken when in_valid is high
//   and in_stall is low. Results leave on out_valid/out_stall the same way.
//   Columns of a matrix arrive in order; last_col closes the matrix, as does
//   reaching MAX_COLS columns.
//   From acceptance to out_valid, a full column passes through multiply,
//   subtract and saturate, the pivot check, the divider steps, taking the
//   quotient and loading the output; column 0 skips multiply and subtract,
//   a zero pivot skips the divider, a quotient overflow skips the divider
//   steps, and a skipped column goes straight to loading the output.
//   in_stall holds until the result is loaded, so no new column is taken before then.
//   The result sits in an output register, so the next item is accepted
//   while the previous result waits; a finished item waits in place while
//   the output register is still held by a stalled result.
//   Reset clears the carried multiplier, column count and error flag and
//   drops any pending result.
// ----------------------------------------------------------------------------
module tridiagonal_lu_factor_top #(
  parameter int MAX_COLS  = tlu_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = tlu_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tlu_pkg::DATA_W-1:0] super_val,
  input  logic signed [tlu_pkg::DATA_W-1:0] diag_val,
  input  logic signed [tlu_pkg::DATA_W-1:0] sub_val,
  input  logic                              last_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tlu_pkg::DATA_W-1:0] pivot_val,
  output logic signed [tlu_pkg::DATA_W-1:0] mult_val,
  output logic [tlu_pkg::STATUS_W-1:0]      status,
  output logic [tlu_pkg::COL_W-1:0]         col_index,
  output logic                              last_out
);

  localparam int DW    = tlu_pkg::DATA_W;
  localparam int WW    = tlu_pkg::WIDE_W;
  localparam int CNT_W = $clog2(MAX_COLS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_SAT  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic signed [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [WW:0] INT_MAX_W = (WW+1)'(INT_MAX);
  localparam logic signed [WW:0] INT_MIN_W = (WW+1)'(INT_MIN);

  logic [2:0] state;
  logic [2:0] state_next;

  // Carried between columns.
  logic signed [DW-1:0] prev_mult;
  logic [CNT_W-1:0]     col_count;
  logic                 failed_flag;

  // Captured item.
  logic signed [DW-1:0] s_reg;
  logic signed [DW-1:0] d_reg;
  logic signed [DW-1:0] a_reg;
  logic                 last_reg;

  // Work registers.
  logic signed [WW-1:0]    prod;
  logic signed [WW:0]      wide;
  logic signed [DW-1:0]    piv;
  logic                    sat;
  logic signed [DW-1:0]    res_mult;
  logic [tlu_pkg::STATUS_W-1:0] res_status;

  logic                 accept;
  logic                 out_free;
  logic signed [WW-1:0] prod_shift;
  logic [DW-1:0]        abs_a;
  logic [DW-1:0]        abs_u;
  logic                 neg;
  logic                 div_start;
  logic [WW-1:0]        div_num;
  tlu_pkg::div_stat_t   div_stat;
  logic [DW-1:0]        div_quot;
  logic signed [DW-1:0] l_val;
  logic                 l_sat;
  logic                 end_matrix;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Floor of the scaled product: arithmetic shift rounds toward minus infinity.
  assign prod_shift = prod >>> FRAC_BITS;

  assign abs_a     = a_reg[DW-1] ? (~a_reg + 1'b1) : a_reg;
  assign abs_u     = piv[DW-1] ? (~piv + 1'b1) : piv;
  assign neg       = a_reg[DW-1] ^ piv[DW-1];
  assign div_num   = WW'(abs_a) << FRAC_BITS;
  assign div_start = (state == S_CHK) && (piv != '0);

  tlu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (abs_u),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Apply sign and saturate the quotient magnitude.
  always_comb begin
    l_val = '0;
    l_sat = 1'b0;
    if (neg) begin
      if (div_stat.ovf || (div_quot > {1'b1, {(DW-1){1'b0}}})) begin
        l_val = INT_MIN;
        l_sat = 1'b1;
      end else begin
        l_val = ~div_quot + 1'b1;
      end
    end else begin
      if (div_stat.ovf || div_quot[DW-1]) begin
        l_val = INT_MAX;
        l_sat = 1'b1;
      end else begin
        l_val = div_quot;
      end
    end
  end

  assign end_matrix = last_reg || (col_count == CNT_W'(MAX_COLS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (failed_flag) begin
            state_next = S_DONE;
          end else if (col_count == '0) begin
            state_next = S_SAT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL:  state_next = S_SUB;
      S_SUB:  state_next = S_SAT;
      S_SAT:  state_next = S_CHK;
      S_CHK:  state_next = (piv == '0) ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prev_mult   <= '0;
      col_count   <= '0;
      failed_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        if (end_matrix) begin
          prev_mult   <= '0;
          col_count   <= '0;
          failed_flag <= 1'b0;
        end else begin
          prev_mult   <= res_mult;
          col_count   <= col_count + 1'b1;
          failed_flag <= failed_flag || (res_status == tlu_pkg::ST_ZERO);
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          s_reg      <= super_val;
          d_reg      <= diag_val;
          a_reg      <= sub_val;
          last_reg   <= last_col;
          wide       <= (WW+1)'(diag_val);
          piv        <= '0;
          res_mult   <= '0;
          res_status <= tlu_pkg::ST_SKIP;
        end
      end
      S_MUL: prod <= prev_mult * s_reg;
      S_SUB: wide <= (WW+1)'(d_reg) - (WW+1)'(prod_shift);
      S_SAT: begin
        // Clamp the pivot to the signed word range.
        if (wide > INT_MAX_W) begin
          piv <= INT_MAX;
          sat <= 1'b1;
        end else if (wide < INT_MIN_W) begin
          piv <= INT_MIN;
          sat <= 1'b1;
        end else begin
          piv <= wide[DW-1:0];
          sat <= 1'b0;
        end
      end
      S_CHK: begin
        if (piv == '0) begin
          res_mult   <= '0;
          res_status <= tlu_pkg::ST_ZERO;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_mult   <= l_val;
          res_status <= (sat || l_sat) ? tlu_pkg::ST_SAT : tlu_pkg::ST_OK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          pivot_val <= piv;
          mult_val  <= res_mult;
          status    <= res_status;
          col_index <= tlu_pkg::COL_W'(col_count);
          last_out  <= last_reg;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
